### design/pcs_pkg.sv
// ---------------------------------------------------------------------------
// pcs_pkg: shared types and constants for the PID step controller
// Fixed-point widths, payload words, microcode fields and the buses between
// the sequencer, the datapath and the quotient unit.
// ---------------------------------------------------------------------------
package pcs_pkg;

    localparam int DATA_W    = 32;                  // signed Q16.16 data
    localparam int FRAC_W    = 16;                  // fraction bits
    localparam int ACC_W     = 48;                  // integral accumulator
    localparam int TERM_W    = 62;                  // clip range of a product term
    localparam int DT_W      = 31;                  // unsigned interval
    localparam int PROD_W    = 64;                  // held product and sums
    localparam int MUL_W     = DATA_W + 1;          // multiplier operand
    localparam int HALF_W    = ACC_W / 2;           // integral split for ki*integral
    localparam int HI_SHIFT  = HALF_W - FRAC_W;     // weight of the upper partial
    localparam int DIV_NUM_W = DATA_W + 1 + FRAC_W; // dividend bits
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRESET   = 3'd4;

    localparam logic [DT_W-1:0] INTERVAL_RESET = 31'd65536;  // 1.0

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] target_value;
        logic signed [DATA_W-1:0] measured_value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive_value;
        logic                     saturated;
    } out_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] gain_p;
        logic signed [DATA_W-1:0] gain_i;
        logic signed [DATA_W-1:0] gain_d;
        logic [DT_W-1:0]          interval;
        logic                     preset_en;
        logic signed [DATA_W-1:0] preset_value;
    } cfg_bus_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_DIV_START,
        OP_INT_UPDATE,
        OP_ACC_LOAD,
        OP_TERM_LOAD,
        OP_TERM_MERGE,
        OP_TERM_CLIP,
        OP_ACC_ADD_TERM,
        OP_ACC_ADD,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        MA_KP,
        MA_KI,
        MA_KD,
        MA_ERR
    } mul_a_t;

    typedef enum logic [2:0] {
        MB_ERR,
        MB_DT,
        MB_DERIV,
        MB_INT_LO,
        MB_INT_HI
    } mul_b_t;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_NO_INPUT,
        COND_DIV_BUSY,
        COND_OUT_FULL
    } cond_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_FINISH
    } div_state_t;

    typedef struct packed {
        op_t    op;
        mul_a_t mul_a;
        mul_b_t mul_b;
        cond_t  cond;
        step_t  jump_tgt;
        logic   last;
    } ucode_t;

    typedef struct packed {
        op_t    op;
        mul_a_t mul_a;
        mul_b_t mul_b;
        logic   fire;
    } seq_ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic div_busy;
        logic out_full;
    } seq_status_t;

    typedef struct packed {
        logic                   start;
        logic signed [DATA_W:0] diff;
        logic [DT_W-1:0]        interval;
    } div_req_t;

    typedef struct packed {
        logic                     busy;
        logic signed [DATA_W-1:0] quotient;
        logic                     clip;
    } div_rsp_t;

endpackage

### design/pcs_divider.sv
// ---------------------------------------------------------------------------
// pcs_divider: bit-serial quotient unit for the derivative term
// Restoring division of |diff| * 2^FRAC_W by the interval, one quotient bit
// per cycle, then sign and saturation to DATA_W bits in a final state.
// ---------------------------------------------------------------------------
module pcs_divider import pcs_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    div_state_t             state_reg, state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_NUM_W-1:0]   work_reg;
    logic [DT_W-1:0]        rem_reg;
    logic [DT_W-1:0]        dvsr_reg;
    logic                   neg_reg;
    logic [DATA_W-1:0]      quot_reg;
    logic                   clip_reg;

    logic [DATA_W:0]        diff_mag;
    logic [DT_W:0]          trial;
    logic [DT_W:0]          trial_sub;
    logic                   take;
    logic [DT_W-1:0]        rem_step;
    logic [DIV_NUM_W-1:0]   sat_lim;
    logic                   over;
    logic [DATA_W:0]        mag;
    logic [DATA_W:0]        res;

    always_comb begin
        diff_mag  = req.diff[DATA_W] ? (DATA_W+1)'(-req.diff) : (DATA_W+1)'(req.diff);
        trial     = {rem_reg, work_reg[DIV_NUM_W-1]};
        trial_sub = trial - {1'b0, dvsr_reg};
        take      = (trial >= {1'b0, dvsr_reg});
        rem_step  = take ? trial_sub[DT_W-1:0] : trial[DT_W-1:0];
        // a negative result may reach one step further than a positive one
        sat_lim   = DIV_NUM_W'({1'b0, {(DATA_W-1){1'b1}}}) + DIV_NUM_W'(neg_reg);
        over      = (work_reg > sat_lim);
        mag       = over ? sat_lim[DATA_W:0] : work_reg[DATA_W:0];
        res       = neg_reg ? ((DATA_W+1)'(0) - mag) : mag;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            DIV_IDLE: begin
                if (req.start) begin
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN: begin
                if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                    state_next = DIV_FINISH;
                end
            end
            DIV_FINISH: begin
                state_next = DIV_IDLE;
            end
            default: begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == DIV_RUN) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            DIV_IDLE: begin
                if (req.start) begin
                    work_reg <= {diff_mag, {FRAC_W{1'b0}}};
                    rem_reg  <= '0;
                    dvsr_reg <= req.interval;
                    neg_reg  <= req.diff[DATA_W];
                end
            end
            DIV_RUN: begin
                work_reg <= {work_reg[DIV_NUM_W-2:0], take};
                rem_reg  <= rem_step;
            end
            DIV_FINISH: begin
                quot_reg <= res[DATA_W-1:0];
                clip_reg <= over;
            end
            default: begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    assign rsp.busy     = (state_reg != DIV_IDLE);
    assign rsp.quotient = quot_reg;
    assign rsp.clip     = clip_reg;

endmodule

### design/pcs_sequencer.sv
// ---------------------------------------------------------------------------
// pcs_sequencer: microprogram store and step counter
// One control word per step; a step whose condition holds jumps to its
// target without executing, otherwise it executes and advances or wraps.
// ---------------------------------------------------------------------------
module pcs_sequencer import pcs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  seq_status_t status,
    output seq_ctrl_t   ctrl
);

    localparam step_t STEP_ACCEPT   = 4'd0;
    localparam step_t STEP_DIV      = 4'd1;
    localparam step_t STEP_INT      = 4'd2;
    localparam step_t STEP_TP       = 4'd3;
    localparam step_t STEP_TI_LO    = 4'd4;
    localparam step_t STEP_TI_HI    = 4'd5;
    localparam step_t STEP_TI_CLIP  = 4'd6;
    localparam step_t STEP_TI_ADD   = 4'd7;
    localparam step_t STEP_DIV_WAIT = 4'd8;
    localparam step_t STEP_TD_ADD   = 4'd9;
    localparam step_t STEP_EMIT     = 4'd10;

    step_t  step_reg, step_next;
    ucode_t word;
    logic   cond_hit;

    function automatic ucode_t uw(input op_t op, input mul_a_t ma, input mul_b_t mb,
                                  input cond_t cond, input step_t tgt, input logic last);
        ucode_t w;
        w.op       = op;
        w.mul_a    = ma;
        w.mul_b    = mb;
        w.cond     = cond;
        w.jump_tgt = tgt;
        w.last     = last;
        return w;
    endfunction

    function automatic ucode_t ucode_rom(input step_t addr);
        ucode_t w;
        case (addr)
            STEP_ACCEPT:   w = uw(OP_ACCEPT, MA_KP, MB_ERR, COND_NO_INPUT, STEP_ACCEPT, 1'b0);
            STEP_DIV:      w = uw(OP_DIV_START, MA_ERR, MB_DT, COND_NONE, STEP_ACCEPT, 1'b0);
            STEP_INT:      w = uw(OP_INT_UPDATE, MA_KP, MB_ERR, COND_NONE, STEP_ACCEPT, 1'b0);
            STEP_TP:       w = uw(OP_ACC_LOAD, MA_KI, MB_INT_LO, COND_NONE, STEP_ACCEPT, 1'b0);
            STEP_TI_LO:    w = uw(OP_TERM_LOAD, MA_KI, MB_INT_HI, COND_NONE, STEP_ACCEPT, 1'b0);
            STEP_TI_HI:    w = uw(OP_TERM_MERGE, MA_KP, MB_ERR, COND_NONE, STEP_ACCEPT, 1'b0);
            STEP_TI_CLIP:  w = uw(OP_TERM_CLIP, MA_KP, MB_ERR, COND_NONE, STEP_ACCEPT, 1'b0);
            STEP_TI_ADD:   w = uw(OP_ACC_ADD_TERM, MA_KP, MB_ERR, COND_NONE, STEP_ACCEPT,
                                  1'b0);
            STEP_DIV_WAIT: w = uw(OP_NOP, MA_KD, MB_DERIV, COND_DIV_BUSY, STEP_DIV_WAIT, 1'b0);
            STEP_TD_ADD:   w = uw(OP_ACC_ADD, MA_KP, MB_ERR, COND_NONE, STEP_ACCEPT, 1'b0);
            STEP_EMIT:     w = uw(OP_EMIT, MA_KP, MB_ERR, COND_OUT_FULL, STEP_EMIT, 1'b1);
            default:       w = uw(OP_NOP, MA_KP, MB_ERR, COND_NONE, STEP_ACCEPT, 1'b1);
        endcase
        return w;
    endfunction

    always_comb begin
        word = ucode_rom(step_reg);
        case (word.cond)
            COND_NONE:     cond_hit = 1'b0;
            COND_NO_INPUT: cond_hit = !status.in_valid;
            COND_DIV_BUSY: cond_hit = status.div_busy;
            COND_OUT_FULL: cond_hit = status.out_full;
            default:       cond_hit = 1'b0;
        endcase
        if (cond_hit) begin
            step_next = word.jump_tgt;
        end else if (word.last) begin
            step_next = STEP_ACCEPT;
        end else begin
            step_next = step_reg + 1'b1;
        end
        ctrl.op    = word.op;
        ctrl.mul_a = word.mul_a;
        ctrl.mul_b = word.mul_b;
        ctrl.fire  = !cond_hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_ACCEPT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

### design/pcs_datapath.sv
// ---------------------------------------------------------------------------
// pcs_datapath: error, integral, shared multiplier and term accumulation
// Executes one micro-operation per step; holds the controller state and the
// output word register.
// ---------------------------------------------------------------------------
module pcs_datapath import pcs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_bus_t  cfg,
    input  seq_ctrl_t ctrl,
    input  in_item_t  s_data,
    input  logic      m_ready,
    output logic      m_valid,
    output out_item_t m_data,
    output div_req_t  div_req,
    input  div_rsp_t  div_rsp
);

    logic signed [DATA_W-1:0] err_reg;
    logic signed [DATA_W-1:0] last_error_reg;
    logic signed [ACC_W-1:0]  integral_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] term_reg;
    logic                     clip_reg;
    logic                     m_valid_reg;
    out_item_t                m_data_reg;

    logic [DT_W-1:0]            dt_eff;
    logic signed [DATA_W:0]     diff_in;
    logic                       err_ovf;
    logic signed [DATA_W-1:0]   err_sat;
    logic signed [MUL_W-1:0]    mul_a_val;
    logic signed [MUL_W-1:0]    mul_b_val;
    logic signed [2*MUL_W-1:0]  prod_full;
    logic signed [PROD_W-1:0]   prod_sh;
    logic signed [ACC_W-1:0]    inc;
    logic signed [ACC_W:0]      int_sum;
    logic                       int_ovf;
    logic signed [ACC_W-1:0]    int_sat;
    logic [PROD_W-TERM_W:0]     term_top;
    logic                       term_ovf;
    logic signed [PROD_W-1:0]   term_sat;
    logic [PROD_W-DATA_W:0]     acc_top;
    logic                       drive_ovf;
    logic signed [DATA_W-1:0]   drive_sat;
    logic                       exec;

    assign exec = ctrl.fire;

    always_comb begin
        dt_eff  = (cfg.interval == '0) ? DT_W'(1) : cfg.interval;
        diff_in = (DATA_W+1)'(s_data.target_value) - (DATA_W+1)'(s_data.measured_value);
        err_ovf = (diff_in[DATA_W] != diff_in[DATA_W-1]);
        if (err_ovf) begin
            err_sat = diff_in[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                      : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            err_sat = diff_in[DATA_W-1:0];
        end

        case (ctrl.mul_a)
            MA_KP:   mul_a_val = MUL_W'(cfg.gain_p);
            MA_KI:   mul_a_val = MUL_W'(cfg.gain_i);
            MA_KD:   mul_a_val = MUL_W'(cfg.gain_d);
            MA_ERR:  mul_a_val = MUL_W'(err_reg);
            default: mul_a_val = '0;
        endcase
        case (ctrl.mul_b)
            MB_ERR:    mul_b_val = MUL_W'(err_reg);
            MB_DT:     mul_b_val = {{(MUL_W-DT_W){1'b0}}, dt_eff};
            MB_DERIV:  mul_b_val = MUL_W'(div_rsp.quotient);
            MB_INT_LO: mul_b_val = {{(MUL_W-HALF_W){1'b0}}, integral_reg[HALF_W-1:0]};
            MB_INT_HI: mul_b_val = MUL_W'(signed'(integral_reg[ACC_W-1:HALF_W]));
            default:   mul_b_val = '0;
        endcase
        prod_full = mul_a_val * mul_b_val;

        // floor division by 2^FRAC_W
        prod_sh = prod_reg >>> FRAC_W;

        inc     = prod_sh[ACC_W-1:0];
        int_sum = (ACC_W+1)'(integral_reg) + (ACC_W+1)'(inc);
        int_ovf = (int_sum[ACC_W] != int_sum[ACC_W-1]);
        if (int_ovf) begin
            int_sat = int_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                     : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            int_sat = int_sum[ACC_W-1:0];
        end

        term_top = term_reg[PROD_W-1:TERM_W-1];
        term_ovf = !((&term_top) || !(|term_top));
        if (term_ovf) begin
            term_sat = term_reg[PROD_W-1]
                     ? {{(PROD_W-TERM_W+1){1'b1}}, {(TERM_W-1){1'b0}}}
                     : {{(PROD_W-TERM_W+1){1'b0}}, {(TERM_W-1){1'b1}}};
        end else begin
            term_sat = term_reg;
        end

        acc_top   = acc_reg[PROD_W-1:DATA_W-1];
        drive_ovf = !((&acc_top) || !(|acc_top));
        if (drive_ovf) begin
            drive_sat = acc_reg[PROD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                          : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            drive_sat = acc_reg[DATA_W-1:0];
        end
    end

    // shared multiplier: register every cycle, consumed by the following step
    always_ff @(posedge aclk) begin
        prod_reg <= prod_full[PROD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            case (ctrl.op)
                OP_ACCEPT: begin
                    err_reg  <= err_sat;
                    clip_reg <= err_ovf;
                end
                OP_ACC_LOAD:     acc_reg  <= prod_sh;
                OP_TERM_LOAD:    term_reg <= prod_sh;
                OP_TERM_MERGE:   term_reg <= term_reg + (prod_reg <<< HI_SHIFT);
                OP_TERM_CLIP: begin
                    term_reg <= term_sat;
                    clip_reg <= clip_reg | term_ovf;
                end
                OP_ACC_ADD_TERM: acc_reg  <= acc_reg + term_reg;
                OP_ACC_ADD:      acc_reg  <= acc_reg + prod_sh;
                OP_EMIT: begin
                    m_data_reg.drive_value <= drive_sat;
                    m_data_reg.saturated   <= clip_reg | div_rsp.clip | drive_ovf;
                end
                OP_INT_UPDATE:   clip_reg <= clip_reg | int_ovf;
                default: begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    // controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_error_reg <= '0;
            integral_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg.preset_en) begin
                last_error_reg <= cfg.preset_value;
            end else if (exec && ctrl.op == OP_EMIT) begin
                last_error_reg <= err_reg;
            end
            if (exec && ctrl.op == OP_INT_UPDATE) begin
                integral_reg <= int_sat;
            end
            if (exec && ctrl.op == OP_EMIT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign div_req.start    = exec && (ctrl.op == OP_DIV_START);
    assign div_req.diff     = (DATA_W+1)'(err_reg) - (DATA_W+1)'(last_error_reg);
    assign div_req.interval = dt_eff;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### design/pid_controller_step.sv
// ---------------------------------------------------------------------------
// pid_controller_step: fixed-point PID controller, one drive word per sample
// Microcoded sequencer over a shared 33x33 multiplier and a bit-serial
// divider for the derivative term.
// ---------------------------------------------------------------------------
// The divider sets the time from input acceptance to m_valid: it forms the
//   49 quotient bits at one bit per cycle, then a sign/saturation step.
// One sample at a time; a held result stalls the emit step.
// The next input word is taken while a finished result still waits on m_.
// Reset (aresetn low, synchronous): gains 0, interval 1.0, previous error and
//   integral cleared, sequencer at its accept step, no result pending.
module pid_controller_step import pcs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration word channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    // sample words in
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    // drive words out
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data
);

    logic signed [DATA_W-1:0] gain_p_reg;
    logic signed [DATA_W-1:0] gain_i_reg;
    logic signed [DATA_W-1:0] gain_d_reg;
    logic [DT_W-1:0]          interval_reg;
    logic                     cfg_wr;

    cfg_bus_t    cfg_bus;
    seq_ctrl_t   seq_ctrl;
    seq_status_t seq_status;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    // Configuration is accepted every cycle and lands at once; the host must
    // write only while no sample is in flight; the block itself leaves this unchecked.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            interval_reg <= INTERVAL_RESET;
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_GAIN_P:   gain_p_reg   <= cfg_data;
                REG_GAIN_I:   gain_i_reg   <= cfg_data;
                REG_GAIN_D:   gain_d_reg   <= cfg_data;
                REG_INTERVAL: interval_reg <= cfg_data[DT_W-1:0];
                default: begin
                    // preset goes straight to the datapath; other indices drop
                    gain_p_reg <= gain_p_reg;
                end
            endcase
        end
    end

    // Preset write loads the previous-error state directly.
    always_comb begin
        cfg_bus.gain_p       = gain_p_reg;
        cfg_bus.gain_i       = gain_i_reg;
        cfg_bus.gain_d       = gain_d_reg;
        cfg_bus.interval     = interval_reg;
        cfg_bus.preset_en    = cfg_wr && (cfg_index == REG_PRESET);
        cfg_bus.preset_value = cfg_data;
    end

    // Sequencer waits on the input at its accept step, on the divider
    // before the derivative product, and on the output register at emit.
    assign seq_status.in_valid = s_valid;
    assign seq_status.div_busy = div_rsp.busy;
    assign seq_status.out_full = m_valid && !m_ready;

    assign s_ready = (seq_ctrl.op == OP_ACCEPT);

    pcs_sequencer u_sequencer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (seq_status),
        .ctrl    (seq_ctrl)
    );

    pcs_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_bus),
        .ctrl    (seq_ctrl),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    pcs_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // The divider must be idle whenever a new sample can be taken.
    a_accept_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_rsp.busy)
        else $error("input offered while divider still busy");

    // One sample at a time: the accept step is left right after acceptance.
    a_single_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second sample accepted back to back");

    // A divide is never launched on top of one in progress.
    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    // The emit step never overwrites a result that has not been taken.
    a_emit_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_ctrl.fire && seq_ctrl.op == OP_EMIT) |-> (!m_valid || m_ready))
        else $error("pending result overwritten");

endmodule
